### hw/rtl/adaptive_lms_noise_canceller_macros.svh
// ----------------------------------------------------------------------------
// adaptive lms noise canceller assertion macros
// shared concurrent assertion forms, clocked on clk_i, quiet in reset
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_LMS_NOISE_CANCELLER_MACROS_SVH
`define ADAPTIVE_LMS_NOISE_CANCELLER_MACROS_SVH

// same-cycle implication
`define ALNC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ALNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/alnc_pkg.sv
// ----------------------------------------------------------------------------
// alnc_pkg
// types and constants shared by the noise canceller controller and datapath
// ----------------------------------------------------------------------------
package alnc_pkg;

  localparam int SMP_W     = 16;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 32;

  // shared multiplier operand and product widths
  localparam int MA_W   = 32;
  localparam int MB_W   = 17;
  localparam int PROD_W = 49;
  // divider: magnitude of mu*e*x stays below 2**46
  localparam int DIV_W  = 46;
  localparam int DIV_CW = 6;
  localparam int TERM_W = 36;
  localparam int CP_W   = 17;

  localparam int LEAK_FACTOR = 328;
  localparam int KEPT_BASE   = 32767;
  localparam int COEF_MAX    = 16384;
  localparam int COEF_MIN    = -32768;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    MODE_LMS        = 3'd0,
    MODE_NLMS       = 3'd1,
    MODE_SIGN_ERR   = 3'd2,
    MODE_SIGN_DATA  = 3'd3,
    MODE_SIGN_SIGN  = 3'd4,
    MODE_LEAKY_LMS  = 3'd5,
    MODE_LEAKY_NLMS = 3'd6,
    MODE_HOLD       = 3'd7
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP = 2'd0,
    CFG_MODE = 2'd1
  } cfg_e;

  typedef enum logic [2:0] {
    MUL_CX, MUL_XX, MUL_MUE, MUL_LEAKF, MUL_TX, MUL_LEAK
  } mul_sel_e;

  typedef enum logic [1:0] {
    WB_KEEP, WB_WRITE, WB_UPDATE
  } wb_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_SHIFT, ST_FIR, ST_FIR_END, ST_NORM, ST_NORM_END,
    ST_ERR, ST_MUE, ST_KEEP, ST_KEEP_LD, ST_TAP_MUL, ST_TAP_LEAK, ST_TAP_CP,
    ST_DIV, ST_DIV_END, ST_TAP_WB, ST_RW, ST_FINISH
  } state_e;

  typedef struct packed {
    logic     load;
    logic     shift_in;
    logic     rot_line;
    logic     rot_coef;
    wb_e      wb;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     nrm_add;
    logic     err_ld;
    logic     p1_ld;
    logic     kept_ld;
    logic     term_ld;
    logic     cp_ld;
    logic     div_start;
    logic     div_step;
    logic     div_done;
    logic     rd_cap;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic is_nlms;
    logic mode_hold;
    logic norm_zero;
  } stat_t;

endpackage

### hw/rtl/alnc_ctrl.sv
// ----------------------------------------------------------------------------
// alnc_ctrl
// sequencer for the tap passes, the per-tap update steps and the divider
// ----------------------------------------------------------------------------
`include "adaptive_lms_noise_canceller_macros.svh"

module alnc_ctrl import alnc_pkg::*; #(
  parameter int NUM_TAPS = 16,
  parameter int KW       = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          m_ready_i,
  input  stat_t         stat_i,
  output cmd_t          cmd_o,
  output logic [KW-1:0] tap_k_o
);

  state_e              state_q, state_d;
  logic [KW-1:0]       k_q, k_d;
  logic [DIV_CW-1:0]   div_q, div_d;
  logic                out_valid_q;
  logic                k_last;

  assign k_last      = (k_q == KW'(NUM_TAPS - 1));
  assign tap_k_o     = k_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      div_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      div_q   <= div_d;
      if (cmd_o.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    div_d      = div_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        k_d = '0;
        unique case (stat_i.req)
          REQ_SAMPLE: state_d = ST_SHIFT;
          REQ_WRITE:  state_d = ST_RW;
          REQ_READ:   state_d = ST_RW;
          REQ_NONE:   state_d = ST_FINISH;
          default:    state_d = ST_FINISH;
        endcase
      end
      ST_SHIFT: begin
        cmd_o.shift_in = 1'b1;
        cmd_o.acc_clr  = 1'b1;
        state_d        = ST_FIR;
      end
      ST_FIR: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_CX;
        cmd_o.rot_line = 1'b1;
        cmd_o.rot_coef = 1'b1;
        cmd_o.wb       = WB_KEEP;
        cmd_o.acc_add  = (k_q != '0);
        if (k_last) begin
          k_d     = '0;
          state_d = ST_FIR_END;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_FIR_END: begin
        cmd_o.acc_add = 1'b1;
        state_d       = stat_i.is_nlms ? ST_NORM : ST_ERR;
      end
      ST_NORM: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_XX;
        cmd_o.rot_line = 1'b1;
        cmd_o.nrm_add  = (k_q != '0);
        if (k_last) begin
          k_d     = '0;
          state_d = ST_NORM_END;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_NORM_END: begin
        cmd_o.nrm_add = 1'b1;
        state_d       = ST_ERR;
      end
      ST_ERR: begin
        cmd_o.err_ld = 1'b1;
        state_d      = ST_MUE;
      end
      ST_MUE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_MUE;
        state_d       = ST_KEEP;
      end
      ST_KEEP: begin
        cmd_o.p1_ld   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LEAKF;
        state_d       = ST_KEEP_LD;
      end
      ST_KEEP_LD: begin
        cmd_o.kept_ld = 1'b1;
        state_d       = stat_i.mode_hold ? ST_FINISH : ST_TAP_MUL;
      end
      ST_TAP_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_TX;
        state_d       = ST_TAP_LEAK;
      end
      ST_TAP_LEAK: begin
        cmd_o.term_ld   = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_LEAK;
        state_d         = ST_TAP_CP;
      end
      ST_TAP_CP: begin
        cmd_o.cp_ld = 1'b1;
        if (stat_i.is_nlms && !stat_i.norm_zero) begin
          div_d   = '0;
          state_d = ST_DIV;
        end else begin
          state_d = ST_TAP_WB;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (div_q == DIV_CW'(DIV_W - 1)) begin
          state_d = ST_DIV_END;
        end else begin
          div_d = div_q + 1'b1;
        end
      end
      ST_DIV_END: begin
        cmd_o.div_done = 1'b1;
        state_d        = ST_TAP_WB;
      end
      ST_TAP_WB: begin
        cmd_o.rot_coef = 1'b1;
        cmd_o.rot_line = 1'b1;
        cmd_o.wb       = WB_UPDATE;
        if (k_last) begin
          k_d     = '0;
          state_d = ST_FINISH;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_TAP_MUL;
        end
      end
      ST_RW: begin
        cmd_o.rot_coef = 1'b1;
        cmd_o.wb       = WB_WRITE;
        cmd_o.rd_cap   = 1'b1;
        if (k_last) begin
          k_d     = '0;
          state_d = ST_FINISH;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `ALNC_ASSERT_IMPL(a_out_ld_free, cmd_o.out_ld, (!out_valid_q || m_ready_i), "result overwritten")
  `ALNC_ASSERT_NEXT(a_busy_after_accept, (in_valid_i && in_ready_o), !in_ready_o, "second accept")
  `ALNC_ASSERT_IMPL(a_div_nlms, cmd_o.div_step, (stat_i.is_nlms && !stat_i.norm_zero), "bad divide")
  `ALNC_ASSERT_IMPL(a_tap_range, state_q != ST_IDLE, (k_q <= KW'(NUM_TAPS - 1)), "tap count overrun")

endmodule

### hw/rtl/alnc_dp.sv
// ----------------------------------------------------------------------------
// alnc_dp
// tap line, coefficient ring, shared multiplier, accumulators, divider
// ----------------------------------------------------------------------------
module alnc_dp import alnc_pkg::*; #(
  parameter int NUM_TAPS = 16,
  parameter int KW       = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [KW-1:0]        tap_k_i,
  output stat_t                stat_o,
  input  logic [S_TDATA_W-1:0] in_data_i,
  input  logic [S_TUSER_W-1:0] in_user_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SMP_W-1:0]     cfg_data_i,
  output logic [M_TDATA_W-1:0] out_data_o
);

  logic signed [SMP_W-1:0]  line_q [NUM_TAPS];
  logic signed [SMP_W-1:0]  coef_q [NUM_TAPS];
  logic signed [SMP_W-1:0]  step_q;
  mode_e                    mode_q;
  req_e                     req_q;
  logic signed [SMP_W-1:0]  sig_q, ref_q, val_q;
  logic [IDX_W-1:0]         idx_q;
  logic [31:0]              acc_q, nrm_q;
  logic signed [SMP_W-1:0]  err_q;
  logic signed [MA_W-1:0]   p1_q;
  logic signed [MB_W-1:0]   kept_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [TERM_W-1:0] term_q;
  logic signed [CP_W-1:0]   cp_q;
  logic [DIV_W-1:0]         dvd_q;
  logic [SMP_W:0]           rem_q;
  logic                     qneg_q;
  logic signed [SMP_W-1:0]  rd_q, err_out_q, tap_rd_q;

  logic signed [SMP_W-1:0]  x_h, c_h, norm, y, wb_val;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [SMP_W:0]    diff;
  logic signed [TERM_W-1:0] term_d;
  logic signed [32:0]       neg_v;
  logic signed [TERM_W:0]   sum;
  logic [SMP_W:0]           dvs, rem_sh;
  logic signed [DIV_W:0]    quot;
  logic                     hit, use_p1, is_leaky;

  assign x_h      = line_q[NUM_TAPS-1];
  assign c_h      = coef_q[0];
  assign norm     = nrm_q[31:16];
  assign y        = acc_q[31:16];
  assign hit      = (9'(idx_q) == 9'(tap_k_i));
  assign use_p1   = (mode_q != MODE_SIGN_ERR);
  assign is_leaky = (mode_q == MODE_LEAKY_LMS) || (mode_q == MODE_LEAKY_NLMS);

  assign stat_o.req       = req_q;
  assign stat_o.is_nlms   = (mode_q == MODE_NLMS) || (mode_q == MODE_LEAKY_NLMS);
  assign stat_o.mode_hold = (mode_q == MODE_HOLD);
  assign stat_o.norm_zero = (norm == '0);

  assign out_data_o = {tap_rd_q, err_out_q};

  // shared multiplier operands
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_CX:    begin mul_a = MA_W'(c_h);         mul_b = MB_W'(x_h);  end
      MUL_XX:    begin mul_a = MA_W'(x_h);         mul_b = MB_W'(x_h);  end
      MUL_MUE:   begin mul_a = MA_W'(step_q);      mul_b = MB_W'(err_q); end
      MUL_LEAKF: begin mul_a = MA_W'(LEAK_FACTOR); mul_b = MB_W'(step_q); end
      MUL_TX:    begin
        mul_a = use_p1 ? p1_q : MA_W'(step_q);
        mul_b = MB_W'(x_h);
      end
      MUL_LEAK:  begin mul_a = MA_W'(c_h);         mul_b = kept_q;       end
      default:   begin mul_a = '0;                 mul_b = '0;           end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // error difference, saturated when loaded into err_q
  assign diff = 17'(sig_q) - 17'(y);

  // update term for the non-dividing rules
  always_comb begin
    term_d = '0;
    neg_v  = '0;
    unique case (mode_q)
      MODE_LMS, MODE_LEAKY_LMS: term_d = TERM_W'(prod_q >>> 30);
      MODE_SIGN_ERR: begin
        neg_v = -(33'(prod_q));
        if (err_q > 0) begin
          term_d = TERM_W'(prod_q >>> 15);
        end else if (err_q < 0) begin
          term_d = TERM_W'(neg_v >>> 15);
        end
      end
      MODE_SIGN_DATA: begin
        neg_v = -(33'(p1_q));
        if (x_h > 0) begin
          term_d = TERM_W'(p1_q >>> 15);
        end else if (x_h < 0) begin
          term_d = TERM_W'(neg_v >>> 15);
        end
      end
      MODE_SIGN_SIGN: begin
        neg_v = -(33'(step_q));
        if ((err_q > 0 && x_h > 0) || (err_q < 0 && x_h < 0)) begin
          term_d = TERM_W'(step_q >>> 3);
        end else if ((err_q > 0 && x_h < 0) || (err_q < 0 && x_h > 0)) begin
          term_d = TERM_W'(neg_v >>> 3);
        end
      end
      default: term_d = '0;
    endcase
  end

  // restoring divider on magnitudes
  assign dvs    = norm[SMP_W-1] ? (SMP_W+1)'(-(17'(norm))) : (SMP_W+1)'(norm);
  assign rem_sh = {rem_q[SMP_W-1:0], dvd_q[DIV_W-1]};
  assign quot   = qneg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

  // write-back: host writes as is, updates saturate to the asymmetric range
  always_comb begin
    sum = (TERM_W+1)'(cp_q) + (TERM_W+1)'(term_q);
    unique case (cmd_i.wb)
      WB_WRITE:  wb_val = (req_q == REQ_WRITE && hit) ? val_q : c_h;
      WB_UPDATE: begin
        if (sum > (TERM_W+1)'(COEF_MAX)) begin
          wb_val = SMP_W'(COEF_MAX);
        end else if (sum < (TERM_W+1)'(COEF_MIN)) begin
          wb_val = SMP_W'(COEF_MIN);
        end else begin
          wb_val = SMP_W'(sum);
        end
      end
      default:   wb_val = c_h;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_TAPS; j++) begin
        line_q[j] <= '0;
        coef_q[j] <= '0;
      end
      step_q <= '0;
      mode_q <= MODE_LMS;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_STEP) begin
          step_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_MODE) begin
          mode_q <= mode_e'(cfg_data_i[2:0]);
        end
      end
      // line rotates towards the top, the head sits at the last tap
      if (cmd_i.shift_in || cmd_i.rot_line) begin
        for (int j = 1; j < NUM_TAPS; j++) begin
          line_q[j] <= line_q[j-1];
        end
        line_q[0] <= cmd_i.shift_in ? ref_q : x_h;
      end
      // coefficient ring rotates towards the bottom, head at entry zero
      if (cmd_i.rot_coef) begin
        for (int j = 0; j < NUM_TAPS - 1; j++) begin
          coef_q[j] <= coef_q[j+1];
        end
        coef_q[NUM_TAPS-1] <= wb_val;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_e'(in_user_i);
      sig_q <= in_data_i[15:0];
      ref_q <= in_data_i[31:16];
      idx_q <= in_data_i[35:32];
      val_q <= in_data_i[51:36];
      rd_q  <= '0;
    end else if (cmd_i.rd_cap && req_q == REQ_READ && hit) begin
      rd_q <= c_h;
    end
    if (cmd_i.mul_en)  prod_q <= mul_p;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
      nrm_q <= '0;
    end else begin
      if (cmd_i.acc_add) acc_q <= acc_q + prod_q[31:0];
      if (cmd_i.nrm_add) nrm_q <= nrm_q + prod_q[31:0];
    end
    if (cmd_i.err_ld) begin
      if (diff > 17'sd32767) begin
        err_q <= 16'sh7fff;
      end else if (diff < -17'sd32768) begin
        err_q <= 16'sh8000;
      end else begin
        err_q <= SMP_W'(diff);
      end
    end
    if (cmd_i.p1_ld)   p1_q   <= MA_W'(prod_q);
    if (cmd_i.kept_ld) kept_q <= MB_W'(KEPT_BASE) - MB_W'(prod_q >>> 13);
    if (cmd_i.div_done) begin
      term_q <= TERM_W'(quot >>> 14);
    end else if (cmd_i.term_ld) begin
      term_q <= term_d;
    end
    if (cmd_i.cp_ld) cp_q <= is_leaky ? CP_W'(prod_q >>> 15) : CP_W'(c_h);
    if (cmd_i.div_start) begin
      dvd_q  <= prod_q[PROD_W-1] ? DIV_W'(-prod_q) : DIV_W'(prod_q);
      rem_q  <= '0;
      qneg_q <= prod_q[PROD_W-1] ^ norm[SMP_W-1];
    end else if (cmd_i.div_step) begin
      if (rem_sh >= dvs) begin
        rem_q <= rem_sh - dvs;
        dvd_q <= {dvd_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
      end
    end
    if (cmd_i.out_ld) begin
      err_out_q <= (req_q == REQ_SAMPLE) ? err_q : '0;
      tap_rd_q  <= rd_q;
    end
  end

endmodule

### hw/rtl/adaptive_lms_noise_canceller.sv
// ----------------------------------------------------------------------------
// adaptive_lms_noise_canceller
// adaptive fir noise canceller with lms, nlms, sign and leaky update rules
// ----------------------------------------------------------------------------
//  channel | direction | transfer moves
//  s_axis  | in        | one request: sample, coefficient write or read
//  m_axis  | out       | one result per request: error and coefficient read
//  cfg     | in        | register write: step size or algorithm mode
//
//  a sample runs the fir pass, the norm pass for nlms, the error and step
//  products, then the per-tap update steps (hold mode skips these), with the
//  46-step restoring divider per tap in nlms modes with a nonzero norm
//  coefficient write or read: one ring rotation
//  reset clears tap line, coefficients and registers at once, no sweep
//  a finished result sits in the output register, so the next request is
//  taken while the sink stalls; the item after that waits for the slot
// ----------------------------------------------------------------------------
module adaptive_lms_noise_canceller import alnc_pkg::*; #(
  parameter int NUM_TAPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // slave side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // primary_sample[15:0], noise_ref[31:16], tap_index[35:32],
  // tap_value[51:36], zero pad [55:52]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  // master side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // error_out[15:0], tap_read[31:16]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SMP_W-1:0]     cfg_data_i
);

  // tap counter width
  localparam int KW = $clog2(NUM_TAPS);

  cmd_t          cmd;
  stat_t         stat;
  logic [KW-1:0] tap_k;

  // user must change registers only while idle, unchecked; writes always taken
  assign cfg_ready_o = 1'b1;

  // sequencer: passes over the taps and per-tap update steps
  alnc_ctrl #(
    .NUM_TAPS (NUM_TAPS),
    .KW       (KW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .tap_k_o     (tap_k)
  );

  // datapath: tap line, coefficient ring, multiplier, divider, result register
  alnc_dp #(
    .NUM_TAPS (NUM_TAPS),
    .KW       (KW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .tap_k_i     (tap_k),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata)
  );

endmodule

### bench/adaptive_lms_noise_canceller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adaptive_lms_noise_canceller_tb
// self-checking bench: requests stream in from a queue, an in-bench model of
// the tap line and coefficients predicts every result, the monitor compares
// ----------------------------------------------------------------------------
module adaptive_lms_noise_canceller_tb;
  import alnc_pkg::*;

  localparam int TAPS     = 16;
  localparam int WD_LIMIT = 40000;
  localparam int HOLD_LEN = 3000;
  localparam int HOLD_AT  = 300;

  typedef struct {
    req_e        req;
    logic [15:0] sig;
    logic [15:0] nref;
    logic [3:0]  idx;
    logic [15:0] val;
  } canc_req_t;

  typedef struct {
    logic [15:0] err;
    logic [15:0] rd;
  } canc_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SMP_W-1:0]     cfg_data_i = '0;

  adaptive_lms_noise_canceller #(.NUM_TAPS(TAPS)) dut (.*);

  always #5 clk_i = ~clk_i;

  // bench copy of the block state and registers
  logic signed [15:0] line_m [TAPS];
  logic signed [15:0] coef_m [TAPS];
  logic signed [15:0] step_m;
  mode_e              mode_m;

  canc_req_t pending_q [$];
  canc_res_t result_q [$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int n_mismatch   = 0;
  int n_sent       = 0;
  int n_recv       = 0;
  int n_cfg        = 0;
  int hold_cnt     = 0;
  bit held_once    = 1'b0;

  function automatic longint sgn(longint v);
    return (v > 0) ? 64'sd1 : ((v < 0) ? -64'sd1 : 64'sd0);
  endfunction

  // coefficient adaptation after a sample, by the current mode
  function automatic void adapt_coefs(longint e);
    longint mu, kept, norm, x, c, term;
    int     nacc;
    mu   = longint'(step_m);
    kept = 32767 - ((LEAK_FACTOR * mu) >>> 13);
    nacc = 0;
    for (int k = 0; k < TAPS; k++) nacc += int'(line_m[k]) * int'(line_m[k]);
    norm = longint'(nacc >>> 16);
    if (mode_m == MODE_HOLD) return;
    for (int k = 0; k < TAPS; k++) begin
      x = longint'(line_m[TAPS-1-k]);
      c = longint'(coef_m[k]);
      case (mode_m)
        MODE_LMS, MODE_LEAKY_LMS: term = (mu * e * x) >>> 30;
        MODE_NLMS, MODE_LEAKY_NLMS: term = (norm != 0) ? ((mu * e * x) / norm) >>> 14 : 0;
        MODE_SIGN_ERR:  term = (mu * sgn(e) * x) >>> 15;
        MODE_SIGN_DATA: term = (mu * e * sgn(x)) >>> 15;
        default:        term = (mu * sgn(e) * sgn(x)) >>> 3;
      endcase
      if (mode_m == MODE_LEAKY_LMS || mode_m == MODE_LEAKY_NLMS) c = (kept * c) >>> 15;
      c = c + term;
      if (c > COEF_MAX) c = COEF_MAX;
      if (c < COEF_MIN) c = COEF_MIN;
      coef_m[k] = c[15:0];
    end
  endfunction

  // result of one request, updating the bench state
  function automatic canc_res_t predict_result(canc_req_t r);
    canc_res_t res;
    int        facc;
    longint    e;
    res = '{16'h0, 16'h0};
    case (r.req)
      REQ_SAMPLE: begin
        for (int k = TAPS - 1; k > 0; k--) line_m[k] = line_m[k-1];
        line_m[0] = r.nref;
        facc = 0;
        for (int k = 0; k < TAPS; k++) facc += int'(coef_m[k]) * int'(line_m[TAPS-1-k]);
        e = longint'($signed(r.sig)) - longint'(facc >>> 16);
        if (e > 32767) e = 32767;
        if (e < -32768) e = -32768;
        adapt_coefs(e);
        res.err = e[15:0];
      end
      REQ_WRITE: coef_m[r.idx] = r.val;
      REQ_READ:  res.rd = coef_m[r.idx];
      default: ;
    endcase
    return res;
  endfunction

  // driver: offer the next pending request, predict on each transfer
  always @(posedge clk_i) begin
    canc_req_t nx;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        nx.req  = req_e'(s_axis_tuser);
        nx.sig  = s_axis_tdata[15:0];
        nx.nref = s_axis_tdata[31:16];
        nx.idx  = s_axis_tdata[35:32];
        nx.val  = s_axis_tdata[51:36];
        result_q.push_back(predict_result(nx));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          nx = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nx.req;
          s_axis_tdata  <= {4'h0, nx.val, nx.idx, nx.nref, nx.sig};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    canc_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_recv++;
        if (result_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata[15:0] !== want.err || m_axis_tdata[31:16] !== want.rd) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("result %0d: error exp %h got %h, tap exp %h got %h", n_recv,
                       want.err, m_axis_tdata[15:0], want.rd, m_axis_tdata[31:16]);
          end
        end
      end
      // one long sink stall so the block fills and backs up its input
      if (!held_once && n_recv == HOLD_AT) begin
        held_once = 1'b1;
        hold_cnt  = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    int quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WD_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // register write, only with the block idle
  task automatic write_reg(cfg_e idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_STEP) step_m = data;
    else if (idx == CFG_MODE) mode_m = mode_e'(data[2:0]);
    n_cfg++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() > 0 || s_axis_tvalid || result_q.size() > 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic push_req(req_e rq, logic [15:0] sig, logic [15:0] nref,
                          logic [3:0] idx, logic [15:0] val);
    pending_q.push_back('{rq, sig, nref, idx, val});
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // random traffic: mostly samples so the adaptation runs deep
  task automatic push_random(int n);
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 80) push_req(REQ_SAMPLE, rand_word(), rand_word(), 4'($urandom), 16'($urandom));
      else if (p < 88) push_req(REQ_WRITE, 16'($urandom), 16'($urandom), 4'($urandom),
                                rand_word());
      else if (p < 96) push_req(REQ_READ, 16'($urandom), 16'($urandom), 4'($urandom),
                                16'($urandom));
      else push_req(REQ_NONE, 16'($urandom), 16'($urandom), 4'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    mode_e       modes [10];
    logic [15:0] steps [10];
    int          counts [10];
    for (int k = 0; k < TAPS; k++) begin
      line_m[k] = '0;
      coef_m[k] = '0;
    end
    step_m = '0;
    mode_m = MODE_LMS;
    modes  = '{MODE_LMS, MODE_LMS, MODE_NLMS, MODE_SIGN_ERR, MODE_SIGN_DATA,
               MODE_SIGN_SIGN, MODE_LEAKY_LMS, MODE_LEAKY_NLMS, MODE_HOLD, MODE_LMS};
    steps  = '{16'h7fff, 16'h8000, 16'h4000, 16'($urandom), 16'($urandom),
               16'($urandom), 16'h8000, 16'h7fff, 16'($urandom), 16'h1000};
    counts = '{250, 100, 100, 250, 250, 250, 250, 100, 150, 300};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset registers, coefficient extremes, unused request
    push_req(REQ_READ,   16'h0, 16'h0, 4'd5, 16'h0);
    push_req(REQ_WRITE,  16'h0, 16'h0, 4'd0, 16'h8000);
    push_req(REQ_WRITE,  16'h0, 16'h0, 4'd15, 16'h7fff);
    push_req(REQ_READ,   16'h0, 16'h0, 4'd0, 16'h0);
    push_req(REQ_READ,   16'h0, 16'h0, 4'd15, 16'h0);
    push_req(REQ_NONE,   16'hffff, 16'hffff, 4'hf, 16'hffff);
    push_req(REQ_SAMPLE, 16'h7fff, 16'h8000, 4'h0, 16'h0);
    push_req(REQ_SAMPLE, 16'h8000, 16'h7fff, 4'h0, 16'h0);
    push_req(REQ_SAMPLE, 16'h0, 16'h0, 4'h0, 16'h0);
    wait_drained();

    // directed nlms: tiny noise keeps the norm at zero, then large noise
    write_reg(CFG_STEP, 16'h7fff);
    write_reg(CFG_MODE, 16'(MODE_LEAKY_NLMS));
    push_req(REQ_SAMPLE, 16'h1234, 16'h0001, 4'h0, 16'h0);
    push_req(REQ_SAMPLE, 16'h8000, 16'h7fff, 4'h0, 16'h0);
    wait_drained();
    write_reg(CFG_MODE, 16'(MODE_NLMS));
    for (int i = 0; i < 6; i++) push_req(REQ_SAMPLE, rand_word(), 16'h8000, 4'h0, 16'h0);
    push_req(REQ_READ, 16'h0, 16'h0, 4'd3, 16'h0);
    wait_drained();
    // indexes past the register list are dropped
    write_reg(cfg_e'(2'd2), 16'hffff);
    write_reg(cfg_e'(2'd3), 16'h5555);

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_STEP, steps[ph]);
      write_reg(CFG_MODE, 16'(modes[ph]));
      @(negedge clk_i);
      snd_idle_pct = (ph < 4) ? 6 : ((ph < 7) ? 66 : 0);
      rcv_idle_pct = (ph < 4) ? 66 : ((ph < 7) ? 6 : 0);
      push_random(counts[ph]);
      wait_drained();
    end

    $display("covered %0d requests, %0d results, %0d register writes", n_sent, n_recv, n_cfg);
    $display("all eight update modes, coefficient access, zero norm and a long sink stall");
    if (n_mismatch == 0 && result_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
